/* sv/sorted_wire_table_macros.svh */
// Assertion helpers for the sorted wire table.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef SORTED_WIRE_TABLE_MACROS_SVH
`define SORTED_WIRE_TABLE_MACROS_SVH

// Same-cycle implication.
`define SWT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_wire_table: same-cycle check failed");

// Next-cycle implication.
`define SWT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_wire_table: next-cycle check failed");

`endif

/* sv/swt_pkg.sv */
`default_nettype none
package swt_pkg;

	localparam int WIRES     = 256;
	localparam int ADDR_W    = $clog2(WIRES);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int NODE_W    = 10;
	localparam int SOCK_W    = 6;
	localparam int KEY_W     = 2 * (NODE_W + SOCK_W);
	localparam int SRC_SHIFT = NODE_W + SOCK_W;
	localparam int STAT_W    = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	// Compare used by one binary search pass.
	typedef enum logic [1:0] {
		CMP_FULL,  // entry <  key, whole word
		CMP_SRC_LT, // entry source <  key source
		CMP_SRC_LE  // entry source <= key source
	} cmp_mode_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] hi_init;
		cmp_mode_t        mode;
		logic             cmp;
	} srch_ctl_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] mid;
		logic [CNT_W-1:0]  pos;
	} srch_stat_t;

endpackage
`default_nettype wire

/* sv/sorted_wire_table.sv */
// Channel  Handshake          Fields
// -------  -----------------  ------------------------------------------------
// command  start / busy       op, from_node, from_socket, to_node, to_socket
// result   done (one cycle)   status, first_index, conn_count
//
// A command beat is taken at a clock edge with start high and busy low.
// Search step: memory read, then compare. Query: two searches, for the first wire
// from the source and for the first wire past it. Insert: a search for the slot,
// then the entries above it shifted up one by one, the new wire written, then the
// two query searches. Full insert: rejected at once, table untouched.
// Reset clears the wire count and the sequencer; the receiver cannot stall.
`default_nettype none
`include "sorted_wire_table_macros.svh"
module sorted_wire_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         op,
	input  wire logic [swt_pkg::NODE_W-1:0]   from_node,
	input  wire logic [swt_pkg::SOCK_W-1:0]   from_socket,
	input  wire logic [swt_pkg::NODE_W-1:0]   to_node,
	input  wire logic [swt_pkg::SOCK_W-1:0]   to_socket,
	output logic                              done,
	output logic [swt_pkg::STAT_W-1:0]        status,
	output logic [swt_pkg::ADDR_W-1:0]        first_index,
	output logic [swt_pkg::CNT_W-1:0]         conn_count
);
	import swt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,     // issue read of the search midpoint
		S_CMP,    // compare the returned entry, narrow the range
		S_SHIFT,  // move entries pos..count-1 up by one
		S_WRKEY   // drop the new wire into its slot
	} state_t;

	typedef enum logic [1:0] {
		PH_INS,  // search for the insert slot
		PH_LB,   // first wire from the socket
		PH_UB    // first wire past the socket
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [CNT_W-1:0]  count_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  first_q;
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              done_q;
	status_t           status_q;
	logic [ADDR_W-1:0] first_index_q;
	logic [CNT_W-1:0]  conn_count_q;

	// table memory: one write and one registered read per cycle
	logic [KEY_W-1:0]  mem [WIRES];
	logic [KEY_W-1:0]  rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [KEY_W-1:0]  wdata;

	srch_ctl_t         ctl;
	srch_stat_t        stat;

	logic [KEY_W-1:0]  in_key;
	logic              full;
	logic              shift_more;
	logic [CNT_W-1:0]  rd_ptr_m1;
	logic [CNT_W-1:0]  span;

	assign in_key     = {from_node, from_socket, to_node, to_socket};
	assign full       = (count_q == CNT_W'(WIRES));
	assign shift_more = (rd_ptr_q > pos_q);
	assign rd_ptr_m1  = rd_ptr_q - CNT_W'(1);
	assign span       = stat.pos - first_q;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign first_index = first_index_q;
	assign conn_count  = conn_count_q;

	swt_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.key    (key_q),
		.rdata  (rdata_q),
		.stat   (stat)
	);

	// Search control: load a new pass or step the current one.
	always_comb begin
		ctl         = '0;
		ctl.mode    = CMP_FULL;
		ctl.hi_init = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = (op == OP_QUERY) || !full;
					ctl.mode = (op == OP_QUERY) ? CMP_SRC_LT : CMP_FULL;
				end
			end
			S_RD: begin
				if (stat.done && phase_q == PH_LB) begin
					ctl.load = 1'b1;
					ctl.mode = CMP_SRC_LE;
				end
			end
			S_CMP:   ctl.cmp = 1'b1;
			S_SHIFT: ctl.cmp = 1'b0;
			S_WRKEY: begin
				// count grows this cycle, so search one entry further
				ctl.load    = 1'b1;
				ctl.mode    = CMP_SRC_LT;
				ctl.hi_init = count_q + CNT_W'(1);
			end
			default: ctl = '0;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = addr_s1 + ADDR_W'(1);
		raddr  = stat.mid;
		wdata  = rdata_q;
		unique case (state_q)
			S_RD: mem_re = !stat.done;
			S_SHIFT: begin
				// read the next lower entry while writing the last one up
				mem_re = shift_more;
				raddr  = rd_ptr_m1[ADDR_W-1:0];
				mem_we = vld_s1;
			end
			S_WRKEY: begin
				mem_we = 1'b1;
				waddr  = pos_q[ADDR_W-1:0];
				wdata  = key_q;
			end
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			key_q <= in_key;
		end
	end

	// Sequencer and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_INS;
			count_q       <= '0;
			pos_q         <= '0;
			first_q       <= '0;
			rd_ptr_q      <= '0;
			vld_s1        <= 1'b0;
			addr_s1       <= '0;
			done_q        <= 1'b0;
			status_q      <= ST_OK;
			first_index_q <= '0;
			conn_count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (op == OP_QUERY) begin
							phase_q <= PH_LB;
							state_q <= S_RD;
						end else if (full) begin
							// reject at once, table untouched
							done_q        <= 1'b1;
							status_q      <= ST_FULL;
							first_index_q <= '0;
							conn_count_q  <= '0;
						end else begin
							phase_q <= PH_INS;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (!stat.done) begin
						state_q <= S_CMP;
					end else begin
						unique case (phase_q)
							PH_INS: begin
								pos_q    <= stat.pos;
								rd_ptr_q <= count_q;
								vld_s1   <= 1'b0;
								state_q  <= S_SHIFT;
							end
							PH_LB: begin
								first_q <= stat.pos;
								phase_q <= PH_UB;
							end
							PH_UB: begin
								done_q <= 1'b1;
								if (span == '0) begin
									status_q      <= ST_NONE;
									first_index_q <= '0;
								end else begin
									status_q      <= ST_OK;
									first_index_q <= first_q[ADDR_W-1:0];
								end
								conn_count_q <= span;
								state_q      <= S_IDLE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CMP: state_q <= S_RD;
				S_SHIFT: begin
					if (shift_more) begin
						vld_s1   <= 1'b1;
						addr_s1  <= rd_ptr_m1[ADDR_W-1:0];
						rd_ptr_q <= rd_ptr_m1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= S_WRKEY;
						end
					end
				end
				S_WRKEY: begin
					count_q <= count_q + CNT_W'(1);
					phase_q <= PH_LB;
					state_q <= S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the wire count within the table size.
	`SWT_ASSERT_IMP(a_count_max, 1'b1, count_q <= CNT_W'(WIRES))
	// Advance the result beat only as the sequencer returns to idle.
	`SWT_ASSERT_IMP(a_done_idle, done_q, !busy)
	// Grow the count by one after each stored wire.
	`SWT_ASSERT_NXT(a_insert_grow, state_q == S_WRKEY, count_q == $past(count_q) + CNT_W'(1))
	// Drop an insert as full only when the table is really full.
	`SWT_ASSERT_IMP(a_full_real, done_q && status_q == ST_FULL, full)

endmodule
`default_nettype wire

/* sv/swt_search.sv */
`default_nettype none
module swt_search (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire swt_pkg::srch_ctl_t          ctl,
	input  wire logic [swt_pkg::KEY_W-1:0]   key,
	input  wire logic [swt_pkg::KEY_W-1:0]   rdata,
	output swt_pkg::srch_stat_t              stat
);
	import swt_pkg::*;

	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	cmp_mode_t        mode_q;
	logic [CNT_W:0]   sum;
	logic             below;
	logic [KEY_W-SRC_SHIFT-1:0] e_src;
	logic [KEY_W-SRC_SHIFT-1:0] k_src;

	assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign e_src = rdata[KEY_W-1:SRC_SHIFT];
	assign k_src = key[KEY_W-1:SRC_SHIFT];

	always_comb begin
		unique case (mode_q)
			CMP_FULL:   below = rdata < key;
			CMP_SRC_LT: below = e_src < k_src;
			CMP_SRC_LE: below = e_src <= k_src;
			default:    below = 1'b0;
		endcase
	end

	assign stat.done = (lo_q >= hi_q);
	assign stat.mid  = sum[ADDR_W:1];
	assign stat.pos  = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '0;
			hi_q   <= '0;
			mode_q <= CMP_FULL;
		end else if (ctl.load) begin
			lo_q   <= '0;
			hi_q   <= ctl.hi_init;
			mode_q <= ctl.mode;
		end else if (ctl.cmp) begin
			// narrow toward the first entry that is not below the key
			if (below) begin
				lo_q <= {1'b0, stat.mid} + CNT_W'(1);
			end else begin
				hi_q <= {1'b0, stat.mid};
			end
		end
	end

endmodule
`default_nettype wire

/* tb/swt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module swt_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic                       op,
	input  wire logic [swt_pkg::NODE_W-1:0] from_node,
	input  wire logic [swt_pkg::SOCK_W-1:0] from_socket,
	input  wire logic [swt_pkg::NODE_W-1:0] to_node,
	input  wire logic [swt_pkg::SOCK_W-1:0] to_socket,
	input  wire logic                       done,
	input  wire logic [swt_pkg::STAT_W-1:0] status,
	input  wire logic [swt_pkg::ADDR_W-1:0] first_index,
	input  wire logic [swt_pkg::CNT_W-1:0]  conn_count,
	output int                              fail_count,
	output int                              pending
);
	import swt_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] first;
		logic [CNT_W-1:0]  count;
	} conn_info_t;

	// Shadow copy of the table, kept sorted on the packed wire word.
	logic [KEY_W-1:0] wire_keys [WIRES];
	int unsigned      n_wires = 0;
	conn_info_t       conn_expected [$];

	// First slot whose entry, from bit sh up, is not below the key.
	function automatic int unsigned lower_bound(logic [KEY_W-1:0] key, int sh);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = n_wires;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if ((wire_keys[mid] >> sh) < (key >> sh))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// Apply one command beat to the shadow table and return its result.
	function automatic conn_info_t commit_wire_cmd(logic cmd_op, logic [KEY_W-1:0] key);
		conn_info_t  r;
		int unsigned pos;
		int unsigned n;
		r.status = ST_OK;
		r.first  = '0;
		r.count  = '0;
		if (cmd_op == OP_INSERT) begin
			if (n_wires >= WIRES) begin
				r.status = ST_FULL;
			end else begin
				pos = lower_bound(key, 0);
				for (int unsigned i = n_wires; i > pos; i--)
					wire_keys[i] = wire_keys[i-1];
				wire_keys[pos] = key;
				n_wires++;
			end
		end
		if (r.status == ST_OK) begin
			pos = lower_bound(key, SRC_SHIFT);
			n   = 0;
			while (pos + n < n_wires &&
			       (wire_keys[pos+n] >> SRC_SHIFT) == (key >> SRC_SHIFT))
				n++;
			if (n == 0) begin
				r.status = ST_NONE;
			end else begin
				r.first = pos[ADDR_W-1:0];
				r.count = n[CNT_W-1:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : watch
		conn_info_t want;
		if (arst_n) begin
			// Check the result beat first: it belongs to an older command.
			if (done) begin
				if (conn_expected.size() == 0) begin
					$display("%0t: unexpected result beat: status %0d first %0d count %0d",
					         $time, status, first_index, conn_count);
					fail_count++;
				end else begin
					want = conn_expected.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
						         $time, want.status, status);
						fail_count++;
					end
					if (first_index !== want.first) begin
						$display("%0t: first_index expected %0d actual %0d",
						         $time, want.first, first_index);
						fail_count++;
					end
					if (conn_count !== want.count) begin
						$display("%0t: conn_count expected %0d actual %0d",
						         $time, want.count, conn_count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				conn_expected.push_back(commit_wire_cmd(op,
					{from_node, from_socket, to_node, to_socket}));
			pending = conn_expected.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import swt_pkg::*;

	// Longest correct wait is an insert that shifts the whole table; take the
	// limit many times over that.
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_BEATS = 1200;
	// Cycles to watch for stray result beats once everything has drained.
	localparam int DRAIN_CYCLES = 64;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              op     = OP_INSERT;
	logic [NODE_W-1:0] from_node   = '0;
	logic [SOCK_W-1:0] from_socket = '0;
	logic [NODE_W-1:0] to_node     = '0;
	logic [SOCK_W-1:0] to_socket   = '0;

	logic              busy;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] first_index;
	logic [CNT_W-1:0]  conn_count;

	int fail_count;
	int pending;

	// Stimulus bookkeeping: how full the table is, and a few hot values so
	// that sources repeat, counts grow and exact duplicates show up.
	int unsigned       n_inserted = 0;
	bit                quiet      = 1'b0;
	logic [NODE_W-1:0] hot_node [4];
	logic [SOCK_W-1:0] hot_sock [4];
	logic [NODE_W-1:0] last_fn = '0;
	logic [SOCK_W-1:0] last_fs = '0;
	int                stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sorted_wire_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.from_node   (from_node),
		.from_socket (from_socket),
		.to_node     (to_node),
		.to_socket   (to_socket),
		.done        (done),
		.status      (status),
		.first_index (first_index),
		.conn_count  (conn_count)
	);

	swt_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.from_node   (from_node),
		.from_socket (from_socket),
		.to_node     (to_node),
		.to_socket   (to_socket),
		.done        (done),
		.status      (status),
		.first_index (first_index),
		.conn_count  (conn_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Watchdog: count cycles in which neither a command nor a result beat
	// moves, and stop the run once that count hits the limit.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Mostly hot values (extremes among them), otherwise anything.
	function automatic logic [NODE_W-1:0] pick_node();
		if ($urandom_range(0, 99) < 60)
			return hot_node[$urandom_range(0, 3)];
		return NODE_W'($urandom);
	endfunction

	function automatic logic [SOCK_W-1:0] pick_sock();
		if ($urandom_range(0, 99) < 60)
			return hot_sock[$urandom_range(0, 3)];
		return SOCK_W'($urandom);
	endfunction

	// Present one command beat at the current falling edge and hold its
	// fields until the block takes it. Start drops at random (a 12 percent
	// chance), unless a quiet stretch is running, so gaps land on every
	// phase of the block's work. Returns at the falling edge after the beat.
	task automatic send(input logic cmd_op, input logic [NODE_W-1:0] fn,
	                    input logic [SOCK_W-1:0] fs, input logic [NODE_W-1:0] tn,
	                    input logic [SOCK_W-1:0] ts);
		bit taken;
		op          <= cmd_op;
		from_node   <= fn;
		from_socket <= fs;
		to_node     <= tn;
		to_socket   <= ts;
		taken = 1'b0;
		while (!taken) begin
			start <= quiet || ($urandom_range(0, 99) >= 12);
			@(posedge clk);
			taken = start && !busy;
			@(negedge clk);
		end
		if (cmd_op == OP_INSERT) begin
			last_fn = fn;
			last_fs = fs;
			if (n_inserted < WIRES)
				n_inserted++;
		end
	endtask

	initial begin
		int ins_pct;
		int pick;

		hot_node[0] = '0;
		hot_node[1] = '1;
		hot_node[2] = NODE_W'($urandom);
		hot_node[3] = NODE_W'($urandom);
		hot_sock[0] = '0;
		hot_sock[1] = '1;
		hot_sock[2] = SOCK_W'($urandom);
		hot_sock[3] = SOCK_W'($urandom);

		// Hold reset, then release it at a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part.
		// Query on an empty table finds nothing.
		send(OP_QUERY, '0, '0, '0, '0);
		// Both extreme wires, each twice: duplicates go in front of their equals.
		send(OP_INSERT, '0, '0, '0, '0);
		send(OP_INSERT, '1, '1, '1, '1);
		send(OP_INSERT, '1, '1, '1, '1);
		send(OP_INSERT, '0, '0, '0, '0);
		// Destination fields of a query are ignored.
		send(OP_QUERY, '0, '0, '1, '1);
		send(OP_QUERY, '1, '1, '0, '0);
		// Neighbor of an existing source, not stored yet.
		send(OP_QUERY, '1, 6'd62, '1, '1);
		send(OP_INSERT, '1, 6'd62, '0, '0);
		// Same source, destinations out of order: checks the to_node and
		// to_socket ordering in both directions.
		send(OP_INSERT, 10'd512, 6'd32, 10'd5, 6'd5);
		send(OP_INSERT, 10'd512, 6'd32, 10'd3, 6'd9);
		send(OP_INSERT, 10'd512, 6'd32, 10'd5, 6'd4);
		send(OP_INSERT, 10'd512, 6'd32, '1, '1);
		send(OP_INSERT, 10'd512, 6'd32, '0, '0);
		send(OP_INSERT, 10'd512, 6'd32, 10'd7, 6'd0);
		send(OP_QUERY, 10'd512, 6'd32, '0, '0);
		send(OP_QUERY, 10'd512, 6'd31, '0, '0);
		send(OP_QUERY, 10'd512, 6'd33, '0, '0);
		// Sources next to each other across a node boundary.
		send(OP_INSERT, 10'd0, '1, 10'd9, 6'd9);
		send(OP_INSERT, 10'd1, '0, 10'd9, 6'd9);
		send(OP_QUERY, 10'd0, '1, '0, '0);
		send(OP_QUERY, 10'd1, '0, '0, '0);

		// Random part: inserts dominate until the table is full, so queries
		// see long runs per source; after that, rejected inserts and queries
		// that reach the top of the index range.
		for (int k = 0; k < RANDOM_BEATS; k++) begin
			quiet   = (k >= 450 && k < 650);
			ins_pct = (n_inserted < WIRES) ? 65 : 25;
			pick    = $urandom_range(0, 99);
			if (pick < ins_pct)
				send(OP_INSERT, pick_node(), pick_sock(), pick_node(), pick_sock());
			else if (pick < ins_pct + (100 - ins_pct) / 4)
				send(OP_QUERY, last_fn, last_fs, NODE_W'($urandom), SOCK_W'($urandom));
			else
				send(OP_QUERY, pick_node(), pick_sock(),
				     NODE_W'($urandom), SOCK_W'($urandom));
		end
		quiet = 1'b0;
		start <= 1'b0;

		// Drain: wait for every result beat, then watch for strays.
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
